@@ rtl/core/tse_pkg.sv @@
// Package for the TLS server name extractor: channel item types, parse phases
// and protocol constants. No dependencies; imported by tls_sni_extract_top.
package tse_pkg;

   localparam int NAME_MAX = 63;

   localparam logic [5:0]  NO_POS          = 6'(NAME_MAX);
   localparam logic [16:0] PACKET_SAT      = 17'd65536;

   localparam logic [16:0] OFF_TYPE        = 17'd0;
   localparam logic [16:0] OFF_VERSION     = 17'd2;
   localparam logic [16:0] OFF_RECORD_LEN  = 17'd4;
   localparam logic [16:0] OFF_HS_TYPE     = 17'd5;
   localparam logic [16:0] OFF_HS_LEN      = 17'd8;

   localparam logic [24:0] RECORD_HDR_LEN  = 25'd5;
   localparam logic [24:0] HS_HDR_END      = 25'd9;
   localparam logic [17:0] HELLO_FIXED_END = 18'd43;

   localparam logic [7:0]  TYPE_HANDSHAKE  = 8'd22;
   localparam logic [15:0] MIN_VERSION     = 16'h0301;
   localparam logic [7:0]  HS_CLIENT_HELLO = 8'd1;
   localparam logic [15:0] EXT_SERVER_NAME = 16'h0000;
   localparam logic [7:0]  NAME_HOST       = 8'h00;
   localparam logic [7:0]  DOT_CHAR        = 8'h2E;

   typedef enum logic [3:0] {
      PH_HDR,
      PH_SID,
      PH_CS,
      PH_CM,
      PH_EXTLEN,
      PH_EXTHDR,
      PH_SN,
      PH_NAME,
      PH_OK,
      PH_DONE
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_item_type;

   typedef struct packed {
      logic       found;
      logic [7:0] name_byte;
      logic [5:0] name_length;
      logic       run_last;
   } rsp_item_type;

endpackage

@@ rtl/core/tls_sni_extract_top.sv @@
// TLS ClientHello server name extractor: byte parser, name store and result emitter.
// Depends on tse_pkg for item types, parse phases and constants.
//
// Usage:
//   req channel (req_valid/req_stall/req_item): one payload byte per item, last_byte
//   set on the final byte of a packet. Bytes are taken one per cycle unless stalled.
//   rsp channel (rsp_valid/rsp_stall/rsp_item): after each packet, either a run of
//   name bytes (found set, name_length = run length, run_last on the final byte) or
//   a single not-found item with run_last set.
//   csr channel (csr_valid/csr_ready/csr_data): writes name_limit, always ready;
//   write it only while no packet is in flight.
// Result path: job registers, then the read stage (s1), then the output register.
// Throughput: 1 byte per cycle while req_stall is low. A found name is read from
//   the name store one byte per cycle while the output is not stalled, and input is
//   held off until its last byte is issued; a not-found packet holds input off only
//   while the read stage is full. The single read port of the name store sets this.
// Reset: synchronous; clears the parser, drops any pending results and sets
//   name_limit to 63. The name store is not cleared.
// Stall: a stalled result holds in the output register; the emitter and, once it
//   is full, the input wait behind it.
module tls_sni_extract_top
   import tse_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [5:0]   csr_data
);

   function automatic logic [16:0] raise_need(logic [16:0] cur, logic [24:0] want);
      logic [16:0] sat;
      sat = (want > 25'(PACKET_SAT)) ? PACKET_SAT : want[16:0];
      return (sat > cur) ? sat : cur;
   endfunction

   logic [5:0]  name_limit_ff;

   phase_type   phase_ff, phase_in;
   logic [16:0] byte_offset_ff, byte_offset_in;
   logic [31:0] acc_ff, acc_in;
   logic [17:0] nfo_ff, nfo_in;
   logic [17:0] fend_ff, fend_in;
   logic [17:0] ext_end_ff, ext_end_in;
   logic [17:0] name_end_ff, name_end_in;
   logic [16:0] must_ff, must_in;
   logic [5:0]  kept_ff, kept_in;
   logic [5:0]  zpos_ff, zpos_in;
   logic [5:0]  dpos_ff, dpos_in;

   logic [7:0]  name_store_ff [NAME_MAX];
   logic        wr_en;

   logic [7:0]  b;
   logic [17:0] off_ext, at_end, fsum8, fsum16;
   logic [23:0] hdr_acc;
   logic [31:0] fval;
   logic        in_field, field_done, name_in;
   logic [5:0]  keep, copy, run;
   logic        pkt_ok, name_found;

   logic        req_accept, pkt_end;

   logic        job_busy_ff, job_found_ff;
   logic [5:0]  job_len_ff, job_idx_ff;
   logic        s1_valid_ff, s1_found_ff, s1_last_ff;
   logic [5:0]  s1_len_ff;
   logic [7:0]  rd_data_ff;
   logic        rsp_valid_ff;
   rsp_item_type rsp_item_ff;
   logic        s2_free, s1_free, issue, issue_last;

   assign csr_ready = 1'b1;

   assign s2_free    = !rsp_valid_ff || !rsp_stall;
   assign s1_free    = !s1_valid_ff || s2_free;
   assign issue      = job_busy_ff && s1_free;
   assign issue_last = !job_found_ff || (job_idx_ff == job_len_ff - 6'd1);
   assign req_stall  = job_busy_ff && !(issue && issue_last);
   assign req_accept = req_valid && !req_stall;
   assign pkt_end    = req_accept && req_item.last_byte;

   assign b          = req_item.data_byte;
   assign off_ext    = {1'b0, byte_offset_ff};
   assign at_end     = off_ext + 18'd1;
   assign hdr_acc    = {acc_ff[15:0], b};
   assign fval       = {acc_ff[23:0], b};
   assign fsum8      = at_end + {10'd0, fval[7:0]};
   assign fsum16     = at_end + {2'd0, fval[15:0]};
   assign in_field   = (off_ext >= nfo_ff) && (off_ext < fend_ff);
   assign field_done = (at_end == fend_ff);
   assign name_in    = (off_ext >= nfo_ff) && (off_ext < name_end_ff) && (kept_ff < NO_POS);
   assign keep       = (fval[15:0] < 16'(NAME_MAX)) ? fval[5:0] : NO_POS;

   always_comb begin
      phase_in       = phase_ff;
      byte_offset_in = byte_offset_ff;
      acc_in         = acc_ff;
      nfo_in         = nfo_ff;
      fend_in        = fend_ff;
      ext_end_in     = ext_end_ff;
      name_end_in    = name_end_ff;
      must_in        = must_ff;
      kept_in        = kept_ff;
      zpos_in        = zpos_ff;
      dpos_in        = dpos_ff;
      wr_en          = 1'b0;
      if (req_accept && !byte_offset_ff[16]) begin
         byte_offset_in = byte_offset_ff + 17'd1;
         unique case (phase_ff)
            PH_HDR: begin
               acc_in = {8'd0, hdr_acc};
               if (byte_offset_ff == OFF_TYPE && b != TYPE_HANDSHAKE) begin
                  phase_in = PH_DONE;
               end else if (byte_offset_ff == OFF_VERSION && hdr_acc[15:0] < MIN_VERSION) begin
                  phase_in = PH_DONE;
               end else if (byte_offset_ff == OFF_RECORD_LEN) begin
                  must_in = raise_need(must_ff, RECORD_HDR_LEN + 25'(hdr_acc[15:0]));
               end else if (byte_offset_ff == OFF_HS_TYPE && b != HS_CLIENT_HELLO) begin
                  phase_in = PH_DONE;
               end else if (byte_offset_ff == OFF_HS_LEN) begin
                  must_in  = raise_need(must_ff, HS_HDR_END + 25'(hdr_acc));
                  phase_in = PH_SID;
                  nfo_in   = HELLO_FIXED_END;
                  fend_in  = HELLO_FIXED_END + 18'd1;
                  acc_in   = '0;
               end
            end
            PH_SID: begin
               if (in_field) begin
                  acc_in = fval;
                  if (field_done) begin
                     phase_in = PH_CS;
                     nfo_in   = fsum8;
                     fend_in  = fsum8 + 18'd2;
                     acc_in   = '0;
                  end
               end
            end
            PH_CS: begin
               if (in_field) begin
                  acc_in = fval;
                  if (field_done) begin
                     phase_in = PH_CM;
                     nfo_in   = fsum16;
                     fend_in  = fsum16 + 18'd1;
                     acc_in   = '0;
                  end
               end
            end
            PH_CM: begin
               if (in_field) begin
                  acc_in = fval;
                  if (field_done) begin
                     phase_in = PH_EXTLEN;
                     nfo_in   = fsum8;
                     fend_in  = fsum8 + 18'd2;
                     acc_in   = '0;
                  end
               end
            end
            PH_EXTLEN: begin
               if (in_field) begin
                  acc_in = fval;
                  if (field_done) begin
                     ext_end_in = fsum16;
                     acc_in     = '0;
                     if (19'(at_end) + 19'd4 > 19'(fsum16)) begin
                        phase_in = PH_DONE;
                     end else begin
                        phase_in = PH_EXTHDR;
                        nfo_in   = at_end;
                        fend_in  = at_end + 18'd4;
                     end
                  end
               end
            end
            PH_EXTHDR: begin
               if (in_field) begin
                  acc_in = fval;
                  if (field_done) begin
                     acc_in = '0;
                     if (fval[31:16] == EXT_SERVER_NAME && fsum16 <= ext_end_ff) begin
                        if (19'(at_end) + 19'd5 > 19'(ext_end_ff)) begin
                           phase_in = PH_DONE;
                        end else begin
                           must_in  = raise_need(must_ff, 25'(fsum16));
                           phase_in = PH_SN;
                           nfo_in   = at_end;
                           fend_in  = at_end + 18'd5;
                        end
                     end else if (19'(fsum16) + 19'd4 > 19'(ext_end_ff)) begin
                        phase_in = PH_DONE;
                     end else begin
                        phase_in = PH_EXTHDR;
                        nfo_in   = fsum16;
                        fend_in  = fsum16 + 18'd4;
                     end
                  end
               end
            end
            PH_SN: begin
               if (in_field) begin
                  acc_in = fval;
                  if (field_done) begin
                     acc_in = '0;
                     if (fval[23:16] != NAME_HOST || fval[15:0] == 16'd0 ||
                         fsum16 > ext_end_ff) begin
                        phase_in = PH_DONE;
                     end else begin
                        must_in     = raise_need(must_ff, 25'(fsum16));
                        phase_in    = PH_NAME;
                        nfo_in      = at_end;
                        name_end_in = at_end + 18'(keep);
                        kept_in     = '0;
                        zpos_in     = NO_POS;
                        dpos_in     = NO_POS;
                     end
                  end
               end
            end
            PH_NAME: begin
               if (name_in) begin
                  wr_en   = 1'b1;
                  kept_in = kept_ff + 6'd1;
                  if (b == 8'd0 && zpos_ff == NO_POS) begin
                     zpos_in = kept_ff;
                  end
                  if (b == DOT_CHAR && dpos_ff == NO_POS) begin
                     dpos_in = kept_ff;
                  end
                  if (at_end == name_end_ff) begin
                     phase_in = PH_OK;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      pkt_ok     = (phase_in == PH_OK) && !byte_offset_in[16] && (must_in <= byte_offset_in);
      copy       = (kept_in < name_limit_ff) ? kept_in : name_limit_ff;
      run        = (copy < zpos_in) ? copy : zpos_in;
      name_found = pkt_ok && (dpos_in < run);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         name_limit_ff <= NO_POS;
      end else if (csr_valid && csr_ready) begin
         name_limit_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || pkt_end) begin
         phase_ff       <= PH_HDR;
         byte_offset_ff <= '0;
         acc_ff         <= '0;
         nfo_ff         <= '0;
         fend_ff        <= '0;
         ext_end_ff     <= '0;
         name_end_ff    <= '0;
         must_ff        <= '0;
         kept_ff        <= '0;
         zpos_ff        <= NO_POS;
         dpos_ff        <= NO_POS;
      end else begin
         phase_ff       <= phase_in;
         byte_offset_ff <= byte_offset_in;
         acc_ff         <= acc_in;
         nfo_ff         <= nfo_in;
         fend_ff        <= fend_in;
         ext_end_ff     <= ext_end_in;
         name_end_ff    <= name_end_in;
         must_ff        <= must_in;
         kept_ff        <= kept_in;
         zpos_ff        <= zpos_in;
         dpos_ff        <= dpos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         name_store_ff[kept_ff] <= b;
      end
      if (issue && job_found_ff) begin
         rd_data_ff <= name_store_ff[job_idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_busy_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pkt_end) begin
            job_busy_ff <= 1'b1;
         end else if (issue && issue_last) begin
            job_busy_ff <= 1'b0;
         end
         if (issue) begin
            s1_valid_ff <= 1'b1;
         end else if (s2_free) begin
            s1_valid_ff <= 1'b0;
         end
         if (s2_free) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pkt_end) begin
         job_found_ff <= name_found;
         job_len_ff   <= name_found ? run : 6'd0;
         job_idx_ff   <= '0;
      end else if (issue) begin
         job_idx_ff   <= job_idx_ff + 6'd1;
      end
      if (issue) begin
         s1_found_ff <= job_found_ff;
         s1_last_ff  <= issue_last;
         s1_len_ff   <= job_len_ff;
      end
      if (s2_free) begin
         rsp_item_ff.found       <= s1_found_ff;
         rsp_item_ff.name_byte   <= s1_found_ff ? rd_data_ff : 8'd0;
         rsp_item_ff.name_length <= s1_found_ff ? s1_len_ff : 6'd0;
         rsp_item_ff.run_last    <= s1_last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

@@ tb/sni_scoreboard_pkg.sv @@
// Scoreboard for the TLS server name extractor bench: predicts the result items
// of each packet from the bytes taken and checks the items the block returns.
// Depends on tse_pkg for item types, parse phases and protocol constants.
package sni_scoreboard_pkg;
   import tse_pkg::*;

   class sni_scoreboard;
      logic [5:0]   name_limit;
      int unsigned  offset;
      phase_type    phase;
      logic [31:0]  acc;
      int unsigned  field_start;
      int unsigned  field_len;
      int unsigned  ext_end;
      int unsigned  name_end;
      int unsigned  reach;
      int unsigned  kept;
      bit           rejected;
      logic [7:0]   name_bytes [NAME_MAX];
      rsp_item_type expected_names [$];
      int           errors;

      function new();
         name_limit = 6'd63;
         errors = 0;
         clear();
      endfunction

      function void clear();
         offset = 0;
         phase = PH_HDR;
         acc = '0;
         field_start = 0;
         field_len = 0;
         ext_end = 0;
         name_end = 0;
         reach = 0;
         kept = 0;
         rejected = 1'b0;
      endfunction

      function void set_limit(logic [5:0] value);
         name_limit = value;
      endfunction

      function int pending();
         return expected_names.size();
      endfunction

      function void abandon();
         rejected = 1'b1;
         phase = PH_DONE;
      endfunction

      function void extend_reach(int unsigned end_off);
         if (end_off > reach) reach = end_off;
      endfunction

      function void start_field(phase_type next, int unsigned start, int unsigned len);
         phase = next;
         field_start = start;
         field_len = len;
         acc = '0;
      endfunction

      function void ext_header_at(int unsigned start);
         if (start + 4 > ext_end) abandon();
         else start_field(PH_EXTHDR, start, 4);
      endfunction

      function void close_field(logic [31:0] v, int unsigned e);
         int unsigned dlen;
         int unsigned nlen;
         int unsigned keep;
         case (phase)
            PH_SID:    start_field(PH_CS, e + v[7:0], 2);
            PH_CS:     start_field(PH_CM, e + v[15:0], 1);
            PH_CM:     start_field(PH_EXTLEN, e + v[7:0], 2);
            PH_EXTLEN: begin
               ext_end = e + v[15:0];
               ext_header_at(e);
            end
            PH_EXTHDR: begin
               dlen = v[15:0];
               if (v[31:16] == EXT_SERVER_NAME && e + dlen <= ext_end) begin
                  if (e + 5 > ext_end) begin
                     abandon();
                  end else begin
                     extend_reach(e + dlen);
                     start_field(PH_SN, e, 5);
                  end
               end else begin
                  ext_header_at(e + dlen);
               end
            end
            PH_SN: begin
               nlen = v[15:0];
               if (v[23:16] != NAME_HOST || nlen == 0 || e + nlen > ext_end) begin
                  abandon();
               end else begin
                  extend_reach(e + nlen);
                  keep = (nlen < NAME_MAX) ? nlen : NAME_MAX;
                  name_end = e + keep;
                  kept = 0;
                  start_field(PH_NAME, e, keep);
               end
            end
            default: ;
         endcase
      endfunction

      function void parse_byte(int unsigned off, logic [7:0] b);
         if (phase == PH_HDR) begin
            acc = {8'h00, acc[15:0], b};
            if (off == OFF_TYPE && b != TYPE_HANDSHAKE) abandon();
            else if (off == OFF_VERSION && acc[15:0] < MIN_VERSION) abandon();
            else if (off == OFF_RECORD_LEN) extend_reach(RECORD_HDR_LEN + acc[15:0]);
            else if (off == OFF_HS_TYPE && b != HS_CLIENT_HELLO) abandon();
            else if (off == OFF_HS_LEN) begin
               extend_reach(HS_HDR_END + acc[23:0]);
               start_field(PH_SID, HELLO_FIXED_END, 1);
            end
            return;
         end
         if (phase == PH_NAME) begin
            if (off >= field_start && off < name_end && kept < NAME_MAX) begin
               name_bytes[kept] = b;
               kept++;
               if (off + 1 == name_end) phase = PH_OK;
            end
            return;
         end
         if (phase >= PH_SID && phase <= PH_SN && off >= field_start &&
             off < field_start + field_len) begin
            acc = {acc[23:0], b};
            if (off + 1 == field_start + field_len) close_field(acc, off + 1);
         end
      endfunction

      function void note_byte(req_item_type it);
         int unsigned  off;
         int unsigned  lim;
         int unsigned  copy;
         int unsigned  run;
         int unsigned  k;
         bit           dot;
         rsp_item_type r;
         off = offset;
         if (off < PACKET_SAT) parse_byte(off, it.data_byte);
         if (offset < PACKET_SAT) offset++;
         if (!it.last_byte) return;
         run = 0;
         dot = 1'b0;
         if (!rejected && phase == PH_OK && offset < PACKET_SAT && reach <= offset) begin
            lim = (name_limit < NAME_MAX) ? name_limit : NAME_MAX;
            copy = (kept < lim) ? kept : lim;
            while (run < copy && name_bytes[run] != 8'h00) begin
               if (name_bytes[run] == DOT_CHAR) dot = 1'b1;
               run++;
            end
            if (!dot) run = 0;
         end
         if (run == 0) begin
            r.found = 1'b0;
            r.name_byte = 8'h00;
            r.name_length = 6'd0;
            r.run_last = 1'b1;
            expected_names.push_back(r);
         end else begin
            for (k = 0; k < run; k++) begin
               r.found = 1'b1;
               r.name_byte = name_bytes[k];
               r.name_length = 6'(run);
               r.run_last = (k + 1 == run);
               expected_names.push_back(r);
            end
         end
         clear();
      endfunction

      function void report(string what, logic [7:0] want, logic [7:0] got);
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
         errors++;
      endfunction

      function void check_result(rsp_item_type got);
         rsp_item_type want;
         if (expected_names.size() == 0) begin
            $display("%0t: result item with nothing outstanding, expected none, actual %h",
                     $time, got);
            errors++;
            return;
         end
         want = expected_names.pop_front();
         if (got.found !== want.found) report("found", want.found, got.found);
         if (got.name_byte !== want.name_byte) report("name_byte", want.name_byte, got.name_byte);
         if (got.name_length !== want.name_length)
            report("name_length", want.name_length, got.name_length);
         if (got.run_last !== want.run_last) report("run_last", want.run_last, got.run_last);
      endfunction
   endclass

endpackage

@@ tb/tb_tls_sni_extract_top.sv @@
// Top of the TLS server name extractor bench: builds ClientHello packets, clean
// and damaged, drives them with random gaps and stalls, and checks every result.
// Depends on tse_pkg, sni_scoreboard_pkg and tls_sni_extract_top.
module tb_tls_sni_extract_top;
   import tse_pkg::*;
   import sni_scoreboard_pkg::*;

   typedef enum int {
      FL_NONE, FL_TYPE, FL_VERSION, FL_HS_TYPE, FL_REC_LONG, FL_HS_LONG, FL_EXT_SHORT,
      FL_EXT_LONG, FL_NAME_TYPE, FL_NAME_EMPTY, FL_SN_OVERRUN, FL_TRUNC
   } flaw_type;

   typedef enum int {HOST_DOTTED, HOST_DOTLESS, HOST_ZERO, HOST_RAW} host_style;

   localparam int CYCLE_LIMIT    = 2_000_000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int TOTAL_ITEMS    = 370;
   localparam int HOLD_CYCLES    = 400;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   req_item_type req_item = '0;
   logic         rsp_stall = 1'b0;
   logic         csr_valid = 1'b0;
   logic [5:0]   csr_data = '0;
   logic         req_stall;
   logic         rsp_valid;
   logic         csr_ready;
   rsp_item_type rsp_item;

   sni_scoreboard score;
   logic [7:0]    packet_q [$];
   logic [7:0]    host_q [$];
   bit            quiet = 1'b0;
   bit            hold_pending = 1'b0;
   int            items_sent = 0;
   int            cycles = 0;

   tls_sni_extract_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial forever #1 clock = ~clock;

   initial begin
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   task automatic send_packet();
      req_item_type item;
      int           gap;
      int           i;
      for (i = 0; i < packet_q.size(); i++) begin
         item.data_byte = packet_q[i];
         item.last_byte = (i == packet_q.size() - 1);
         gap = quiet ? 0 : $urandom_range(0, 3);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_item <= item;
         do @(posedge clock); while (req_stall);
         score.note_byte(item);
         items_sent++;
      end
   endtask

   task automatic write_limit(logic [5:0] value);
      req_valid <= 1'b0;
      while (score.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      score.set_limit(value);
      csr_valid <= 1'b0;
   endtask

   task automatic make_host(int len, host_style style);
      int i;
      host_q.delete();
      for (i = 0; i < len; i++) begin
         if (style == HOST_RAW) host_q.push_back(8'($urandom));
         else host_q.push_back(8'(8'h61 + $urandom_range(0, 25)));
      end
      if (style != HOST_DOTLESS && style != HOST_RAW) host_q[$urandom_range(0, len - 1)] = DOT_CHAR;
      if (style == HOST_ZERO) host_q[$urandom_range(0, len - 1)] = 8'h00;
   endtask

   task automatic build_hello(flaw_type flaw, logic [15:0] version);
      logic [7:0]  body [$];
      logic [7:0]  exts [$];
      int          n_other;
      int          sn_pos;
      int          nlen;
      int          dlen;
      int          ext_len;
      int          hs_len;
      int          rec_len;
      int          fill;
      int          i;
      logic [15:0] etype;
      nlen = host_q.size();
      n_other = $urandom_range(0, 2);
      sn_pos = $urandom_range(0, n_other);
      for (i = 0; i <= n_other; i++) begin
         if (i == sn_pos) begin
            dlen = 5 + nlen;
            if (flaw == FL_SN_OVERRUN) dlen += $urandom_range(24, 200);
            exts.push_back(EXT_SERVER_NAME[15:8]);
            exts.push_back(EXT_SERVER_NAME[7:0]);
            exts.push_back(8'(dlen >> 8));
            exts.push_back(8'(dlen));
            exts.push_back(8'((nlen + 3) >> 8));
            exts.push_back(8'(nlen + 3));
            exts.push_back((flaw == FL_NAME_TYPE) ? 8'($urandom_range(1, 255)) : NAME_HOST);
            exts.push_back((flaw == FL_NAME_EMPTY) ? 8'h00 : 8'(nlen >> 8));
            exts.push_back((flaw == FL_NAME_EMPTY) ? 8'h00 : 8'(nlen));
            foreach (host_q[j]) exts.push_back(host_q[j]);
         end else begin
            etype = 16'($urandom_range(1, 16'hFFFF));
            dlen = $urandom_range(0, 6);
            exts.push_back(etype[15:8]);
            exts.push_back(etype[7:0]);
            exts.push_back(8'(dlen >> 8));
            exts.push_back(8'(dlen));
            repeat (dlen) exts.push_back(8'($urandom));
         end
      end
      ext_len = exts.size();
      if (flaw == FL_EXT_SHORT) ext_len -= $urandom_range(1, ext_len);
      if (flaw == FL_EXT_LONG) ext_len += $urandom_range(1, 300);

      body.push_back(8'h03);
      body.push_back(8'h03);
      repeat (32) body.push_back(8'($urandom));
      fill = ($urandom_range(0, 3) == 0) ? 32 : $urandom_range(0, 8);
      body.push_back(8'(fill));
      repeat (fill) body.push_back(8'($urandom));
      fill = 2 * $urandom_range(0, 4);
      body.push_back(8'(fill >> 8));
      body.push_back(8'(fill));
      repeat (fill) body.push_back(8'($urandom));
      fill = $urandom_range(1, 2);
      body.push_back(8'(fill));
      repeat (fill) body.push_back(8'($urandom));
      body.push_back(8'(ext_len >> 8));
      body.push_back(8'(ext_len));
      foreach (exts[j]) body.push_back(exts[j]);

      hs_len = body.size();
      rec_len = hs_len + 4;
      if (flaw == FL_REC_LONG) rec_len += $urandom_range(4, 100);
      if (flaw == FL_HS_LONG) hs_len += $urandom_range(4, 100);

      packet_q.delete();
      if (flaw == FL_TYPE) packet_q.push_back(8'(TYPE_HANDSHAKE + $urandom_range(1, 255)));
      else packet_q.push_back(TYPE_HANDSHAKE);
      packet_q.push_back(version[15:8]);
      packet_q.push_back(version[7:0]);
      packet_q.push_back(8'(rec_len >> 8));
      packet_q.push_back(8'(rec_len));
      if (flaw == FL_HS_TYPE) packet_q.push_back(8'(HS_CLIENT_HELLO + $urandom_range(1, 255)));
      else packet_q.push_back(HS_CLIENT_HELLO);
      packet_q.push_back(8'(hs_len >> 16));
      packet_q.push_back(8'(hs_len >> 8));
      packet_q.push_back(8'(hs_len));
      foreach (body[j]) packet_q.push_back(body[j]);
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) packet_q.push_back(8'($urandom));
      if (flaw == FL_TRUNC) repeat ($urandom_range(1, 40)) void'(packet_q.pop_back());
   endtask

   task automatic send_hello(flaw_type flaw, logic [15:0] version);
      build_hello(flaw, version);
      send_packet();
   endtask

   task automatic random_packet();
      int          pick;
      int          len;
      int          shape;
      flaw_type    flaw;
      logic [15:0] version;
      quiet = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 9);
      shape = $urandom_range(0, 9);
      if (shape < 7) len = $urandom_range(1, 16);
      else if (shape < 9) len = $urandom_range(17, NAME_MAX);
      else len = $urandom_range(NAME_MAX + 1, 80);
      shape = $urandom_range(0, 9);
      if (shape < 7) make_host(len, HOST_DOTTED);
      else if (shape == 7) make_host(len, HOST_DOTLESS);
      else if (shape == 8) make_host(len, HOST_ZERO);
      else make_host(len, HOST_RAW);
      if (pick == 0) begin
         packet_q.delete();
         repeat ($urandom_range(1, 60)) packet_q.push_back(8'($urandom));
         send_packet();
      end else begin
         flaw = (pick <= 6) ? FL_NONE : flaw_type'($urandom_range(FL_TYPE, FL_TRUNC));
         if (flaw == FL_VERSION) version = 16'($urandom_range(0, MIN_VERSION - 1));
         else if ($urandom_range(0, 1) == 1) version = 16'h0303;
         else version = 16'($urandom_range(MIN_VERSION, 16'hFFFF));
         send_hello(flaw, version);
      end
   endtask

   initial begin
      int hold;
      wait (reset == 1'b0);
      forever begin
         if (hold_pending) begin
            hold = HOLD_CYCLES;
            hold_pending = 1'b0;
         end else begin
            hold = $urandom_range(0, 3);
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         score.check_result(rsp_item);
      end
   end

   initial begin
      int lim;
      score = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      write_limit(6'd63);

      make_host(12, HOST_DOTLESS);
      host_q[3] = DOT_CHAR;
      host_q[7] = 8'h00;
      send_hello(FL_NONE, MIN_VERSION);
      packet_q.delete();
      packet_q.push_back(TYPE_HANDSHAKE);
      send_packet();

      hold_pending = 1'b1;
      repeat (2) random_packet();
      while (items_sent < TOTAL_ITEMS) begin
         case ($urandom_range(0, 3))
            0:       lim = 0;
            1:       lim = NAME_MAX;
            default: lim = $urandom_range(0, NAME_MAX);
         endcase
         write_limit(6'(lim));
         random_packet();
      end

      req_valid <= 1'b0;
      while (score.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (score.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/tse_pkg.sv
rtl/core/tls_sni_extract_top.sv
tb/sni_scoreboard_pkg.sv
tb/tb_tls_sni_extract_top.sv
